FILE: rtl/ladrc_pkg.sv
// Shared types, constants and fixed-point helpers for the first-order LADRC.
// Used by ladrc_ctrl, ladrc_dp and first_order_ladrc; depends on nothing.
`timescale 1ns / 1ps

package ladrc_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BETA2,
		S_B1E,
		S_B0U,
		S_B2E,
		S_R1DT,
		S_R2DT,
		S_WC,
		S_DIV,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_BETA2,
		OP_B1E,
		OP_B0U,
		OP_B2E,
		OP_R1DT,
		OP_R2DT,
		OP_WC,
		OP_DIV
	} op_t;

	// config register indexes
	localparam logic [1:0] CFG_WO  = 2'd0;
	localparam logic [1:0] CFG_WC  = 2'd1;
	localparam logic [1:0] CFG_B0  = 2'd2;
	localparam logic [1:0] CFG_MAX = 2'd3;

	// step numbers inside one operation
	localparam logic [6:0] STEP_FIRST = 7'd0;
	localparam logic [6:0] STEP_ACC1  = 7'd1;
	localparam logic [6:0] STEP_ACC2  = 7'd2;
	localparam logic [6:0] MUL_LAST   = 7'd4;
	localparam logic [6:0] DIV_LAST   = 7'd65;

	localparam logic signed [47:0] WIDE_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] WIDE_MIN = 48'sh8000_0000_0000;
	localparam logic signed [49:0] SAT_HI   = {2'b00, 48'h7FFF_FFFF_FFFF};
	localparam logic signed [49:0] SAT_LO   = {2'b11, 48'h8000_0000_0000};
	localparam logic signed [31:0] GAIN_ONE = 32'sd65536;

	typedef struct packed {
		logic       load;
		op_t        op;
		logic [6:0] step;
		logic       publish;
	} cmd_t;

	typedef struct packed {
		logic skip;
	} st_t;

	function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
		if (x > SAT_HI)
			return WIDE_MAX;
		else if (x < SAT_LO)
			return WIDE_MIN;
		else
			return x[47:0];
	endfunction

	function automatic logic signed [49:0] sx50(input logic signed [47:0] x);
		return {{2{x[47]}}, x};
	endfunction

	function automatic logic [47:0] mag49(input logic signed [48:0] x);
		logic [48:0] t;
		t = x[48] ? 49'(-x) : x;
		return t[47:0];
	endfunction

endpackage

FILE: rtl/ladrc_ctrl.sv
// Sequencer for the LADRC update: steps the datapath through seven
// multiplications and one division. Depends on ladrc_pkg.
`timescale 1ns / 1ps

module ladrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ladrc_pkg::st_t    st,
	output ladrc_pkg::cmd_t   cmd
);

	ladrc_pkg::state_t state_q, state_nxt;
	logic [6:0] step_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ladrc_pkg::S_IDLE: begin
				if (in_valid)
					state_nxt = st.skip ? ladrc_pkg::S_DONE : ladrc_pkg::S_BETA2;
			end
			ladrc_pkg::S_BETA2: if (step_q == ladrc_pkg::MUL_LAST) state_nxt = ladrc_pkg::S_B1E;
			ladrc_pkg::S_B1E:   if (step_q == ladrc_pkg::MUL_LAST) state_nxt = ladrc_pkg::S_B0U;
			ladrc_pkg::S_B0U:   if (step_q == ladrc_pkg::MUL_LAST) state_nxt = ladrc_pkg::S_B2E;
			ladrc_pkg::S_B2E:   if (step_q == ladrc_pkg::MUL_LAST) state_nxt = ladrc_pkg::S_R1DT;
			ladrc_pkg::S_R1DT:  if (step_q == ladrc_pkg::MUL_LAST) state_nxt = ladrc_pkg::S_R2DT;
			ladrc_pkg::S_R2DT:  if (step_q == ladrc_pkg::MUL_LAST) state_nxt = ladrc_pkg::S_WC;
			ladrc_pkg::S_WC:    if (step_q == ladrc_pkg::MUL_LAST) state_nxt = ladrc_pkg::S_DIV;
			ladrc_pkg::S_DIV:   if (step_q == ladrc_pkg::DIV_LAST) state_nxt = ladrc_pkg::S_DONE;
			ladrc_pkg::S_DONE:  if (out_free) state_nxt = ladrc_pkg::S_IDLE;
			default:            state_nxt = ladrc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.op      = ladrc_pkg::OP_NONE;
		cmd.step    = step_q;
		cmd.publish = 1'b0;
		unique case (state_q)
			ladrc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ladrc_pkg::S_BETA2: cmd.op = ladrc_pkg::OP_BETA2;
			ladrc_pkg::S_B1E:   cmd.op = ladrc_pkg::OP_B1E;
			ladrc_pkg::S_B0U:   cmd.op = ladrc_pkg::OP_B0U;
			ladrc_pkg::S_B2E:   cmd.op = ladrc_pkg::OP_B2E;
			ladrc_pkg::S_R1DT:  cmd.op = ladrc_pkg::OP_R1DT;
			ladrc_pkg::S_R2DT:  cmd.op = ladrc_pkg::OP_R2DT;
			ladrc_pkg::S_WC:    cmd.op = ladrc_pkg::OP_WC;
			ladrc_pkg::S_DIV:   cmd.op = ladrc_pkg::OP_DIV;
			ladrc_pkg::S_DONE:  cmd.publish = out_free;
			default:            cmd.op = ladrc_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ladrc_pkg::S_IDLE;
			step_q      <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// restart the step count on every state change
			step_q  <= (state_nxt != state_q) ? 7'd0 : step_q + 7'd1;
			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ladrc_pkg::S_IDLE))
		else $error("block stayed idle after accepting a request");
	a_mul_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != ladrc_pkg::OP_NONE && cmd.op != ladrc_pkg::OP_DIV) |->
		(step_q <= ladrc_pkg::MUL_LAST))
		else $error("multiply step count overran");
	a_div_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ladrc_pkg::S_DIV) |-> (step_q <= ladrc_pkg::DIV_LAST))
		else $error("divide step count overran");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("result published over a pending one");
`endif

endmodule

FILE: rtl/ladrc_dp.sv
// LADRC datapath: config and observer registers, a 48x16 digit multiplier
// and a restoring divider, all driven by ladrc_ctrl commands. Uses ladrc_pkg.
`timescale 1ns / 1ps

module ladrc_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   action,
	input  logic signed [31:0]     reference,
	input  logic signed [31:0]     measurement,
	input  logic [23:0]            time_step,
	input  ladrc_pkg::cmd_t        cmd,
	output ladrc_pkg::st_t         st,
	output logic signed [31:0]     drive
);

	logic [30:0]        wo_q, wc_q, max_q;
	logic signed [31:0] b0_q, b0_eff;
	logic signed [47:0] z1_q, z2_q;
	logic signed [31:0] last_q, out_q;

	logic signed [31:0] ref_q;
	logic [23:0]        dt_q;
	logic signed [47:0] e_q, beta2_q, t1_q, t2_q, rate1_q, rate2_q, v_q;
	logic [47:0]        a_mag_q, b_mag_q;
	logic               neg_q;
	logic [95:0]        acc_q;
	logic [63:0]        quo_q;
	logic [31:0]        rem_q;

	logic               is_mul;
	logic signed [48:0] a_op, b_op;
	logic signed [47:0] ref_diff;
	logic [15:0]        digit;
	logic [63:0]        pp;
	logic [95:0]        pp_sh;
	logic               sh24;
	logic [79:0]        p80;
	logic signed [47:0] prod;
	logic [31:0]        d_mag;
	logic [32:0]        shifted;
	logic [33:0]        diff;
	logic [30:0]        q_clamp;
	logic signed [49:0] meas_x;

	assign b0_eff  = (b0_q == 32'sd0) ? ladrc_pkg::GAIN_ONE : b0_q;
	assign st.skip = action || (time_step == 24'd0);
	assign drive   = out_q;
	assign is_mul  = (cmd.op != ladrc_pkg::OP_NONE) && (cmd.op != ladrc_pkg::OP_DIV);
	assign sh24    = (cmd.op == ladrc_pkg::OP_R1DT) || (cmd.op == ladrc_pkg::OP_R2DT);
	assign meas_x  = {{18{measurement[31]}}, measurement};
	assign ref_diff = ladrc_pkg::sat48({{18{ref_q[31]}}, ref_q} - ladrc_pkg::sx50(z1_q));

	// operand select for the first step of each multiply
	always_comb begin
		a_op = '0;
		b_op = '0;
		unique case (cmd.op)
			ladrc_pkg::OP_BETA2: begin
				a_op = {18'b0, wo_q};
				b_op = {18'b0, wo_q};
			end
			ladrc_pkg::OP_B1E: begin
				a_op = {17'b0, wo_q, 1'b0};
				b_op = {e_q[47], e_q};
			end
			ladrc_pkg::OP_B0U: begin
				a_op = {{17{b0_eff[31]}}, b0_eff};
				b_op = {{17{last_q[31]}}, last_q};
			end
			ladrc_pkg::OP_B2E: begin
				a_op = {beta2_q[47], beta2_q};
				b_op = {e_q[47], e_q};
			end
			ladrc_pkg::OP_R1DT: begin
				a_op = {rate1_q[47], rate1_q};
				b_op = {25'b0, dt_q};
			end
			ladrc_pkg::OP_R2DT: begin
				a_op = {rate2_q[47], rate2_q};
				b_op = {25'b0, dt_q};
			end
			ladrc_pkg::OP_WC: begin
				a_op = {18'b0, wc_q};
				b_op = {ref_diff[47], ref_diff};
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	// one 16-bit digit of the multiplier per step
	always_comb begin
		if (cmd.step == ladrc_pkg::STEP_ACC1)
			digit = b_mag_q[15:0];
		else if (cmd.step == ladrc_pkg::STEP_ACC2)
			digit = b_mag_q[31:16];
		else
			digit = b_mag_q[47:32];
		pp = {16'b0, a_mag_q} * {48'b0, digit};
		if (cmd.step == ladrc_pkg::STEP_ACC1)
			pp_sh = {32'b0, pp};
		else if (cmd.step == ladrc_pkg::STEP_ACC2)
			pp_sh = {16'b0, pp, 16'b0};
		else
			pp_sh = {pp, 32'b0};
	end

	// scale, truncate toward zero, saturate to 48 bits
	always_comb begin
		p80 = sh24 ? {8'b0, acc_q[95:24]} : acc_q[95:16];
		if (neg_q)
			prod = (p80 > 80'h8000_0000_0000) ? ladrc_pkg::WIDE_MIN : 48'(-p80[47:0]);
		else
			prod = (p80 > 80'h7FFF_FFFF_FFFF) ? ladrc_pkg::WIDE_MAX : p80[47:0];
	end

	always_comb begin
		d_mag   = b0_eff[31] ? 32'(-b0_eff) : b0_eff;
		shifted = {rem_q, quo_q[63]};
		diff    = {1'b0, shifted} - {2'b0, d_mag};
		q_clamp = (quo_q > {33'b0, max_q}) ? max_q : quo_q[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wo_q   <= '0;
			wc_q   <= '0;
			b0_q   <= ladrc_pkg::GAIN_ONE;
			max_q  <= '0;
			z1_q   <= '0;
			z2_q   <= '0;
			last_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ladrc_pkg::CFG_WO:  wo_q  <= cfg_data[30:0];
					ladrc_pkg::CFG_WC:  wc_q  <= cfg_data[30:0];
					ladrc_pkg::CFG_B0:  b0_q  <= cfg_data;
					ladrc_pkg::CFG_MAX: max_q <= cfg_data[30:0];
					default:            wo_q  <= wo_q;
				endcase
			end
			if (cmd.load && action) begin
				z1_q   <= meas_x[47:0];
				z2_q   <= '0;
				last_q <= '0;
			end
			if (cmd.step == ladrc_pkg::MUL_LAST) begin
				if (cmd.op == ladrc_pkg::OP_R1DT)
					z1_q <= ladrc_pkg::sat48(ladrc_pkg::sx50(z1_q) + ladrc_pkg::sx50(prod));
				if (cmd.op == ladrc_pkg::OP_R2DT)
					z2_q <= ladrc_pkg::sat48(ladrc_pkg::sx50(z2_q) + ladrc_pkg::sx50(prod));
			end
			if (cmd.op == ladrc_pkg::OP_DIV && cmd.step == ladrc_pkg::DIV_LAST)
				last_q <= neg_q ? 32'(-{1'b0, q_clamp}) : {1'b0, q_clamp};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ref_q <= reference;
			dt_q  <= time_step;
			e_q   <= ladrc_pkg::sat48(ladrc_pkg::sx50(z1_q) - meas_x);
		end
		if (cmd.publish)
			out_q <= last_q;
		if (is_mul) begin
			if (cmd.step == ladrc_pkg::STEP_FIRST) begin
				a_mag_q <= ladrc_pkg::mag49(a_op);
				b_mag_q <= ladrc_pkg::mag49(b_op);
				neg_q   <= a_op[48] ^ b_op[48];
				acc_q   <= '0;
			end else if (cmd.step == ladrc_pkg::MUL_LAST) begin
				unique case (cmd.op)
					ladrc_pkg::OP_BETA2: beta2_q <= prod;
					ladrc_pkg::OP_B1E:   t1_q    <= prod;
					ladrc_pkg::OP_B0U:   t2_q    <= prod;
					ladrc_pkg::OP_B2E:   rate2_q <= ladrc_pkg::sat48(-ladrc_pkg::sx50(prod));
					ladrc_pkg::OP_WC:
						v_q <= ladrc_pkg::sat48(ladrc_pkg::sx50(prod) - ladrc_pkg::sx50(z2_q));
					default:             acc_q   <= acc_q;
				endcase
			end else begin
				acc_q <= acc_q + pp_sh;
			end
			// rate1 uses the old z2 before the observer advances
			if (cmd.op == ladrc_pkg::OP_B2E && cmd.step == ladrc_pkg::STEP_ACC1)
				rate1_q <= ladrc_pkg::sat48(ladrc_pkg::sx50(z2_q) - ladrc_pkg::sx50(t1_q)
					+ ladrc_pkg::sx50(t2_q));
		end
		if (cmd.op == ladrc_pkg::OP_DIV) begin
			if (cmd.step == ladrc_pkg::STEP_FIRST) begin
				quo_q <= {ladrc_pkg::mag49({v_q[47], v_q}), 16'b0};
				rem_q <= '0;
				neg_q <= v_q[47] ^ b0_eff[31];
			end else if (cmd.step != ladrc_pkg::DIV_LAST) begin
				if (!diff[33]) begin
					rem_q <= diff[31:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= shifted[31:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
		end
	end

endmodule

FILE: rtl/first_order_ladrc.sv
// First-order linear ADRC, top level: joins the sequencer and the datapath.
// Depends on ladrc_pkg, ladrc_ctrl and ladrc_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request: action, reference,
//   measurement and time_step. Each request yields exactly one drive value
//   on the output channel (out_valid/out_ready).
//   An update request runs seven multiplies in turn on the shared 48x16
//   digit multiplier, then the one-bit-per-cycle restoring divider, then
//   loads the output register once out_valid is clear or out_ready is
//   high. A reset request or a zero time step skips the multiplies and
//   the divider and goes straight to that load. One request is in work at
//   a time; in_ready is high only while the sequencer is idle, so a new
//   request is not accepted until the last one has loaded the output register.
//   The output register holds the last result; a new request is accepted
//   while it waits, and its result waits in turn until out_ready frees it.
//   Config writes (cfg_we, cfg_index, cfg_data) take effect at once and
//   belong only in idle periods.
//   At reset the observer states, the held result, the gains and the limit
//   clear, the plant gain returns to 1.0 and the drive register has no reset.
`timescale 1ns / 1ps

module first_order_ladrc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] reference,
	input  logic signed [31:0] measurement,
	input  logic [23:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] drive
);

	ladrc_pkg::cmd_t cmd;
	ladrc_pkg::st_t  st;

	ladrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	ladrc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.reference   (reference),
		.measurement (measurement),
		.time_step   (time_step),
		.cmd         (cmd),
		.st          (st),
		.drive       (drive)
	);

endmodule
